// ===== hdl/fsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared widths, types and plane helpers for the frustum sphere cull unit.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int unsigned PLANE_COUNT = 6;

    localparam int unsigned COL_COUNT  = 4;
    localparam int unsigned COL_W      = 64;
    localparam int unsigned ELEM_W     = 16;
    localparam int unsigned CFG_ADDR_W = 5;

    localparam int unsigned CTR_W    = 24;
    localparam int unsigned RAD_W    = 23;
    localparam int unsigned R2_W     = 46;
    localparam int unsigned R2_HALF  = 23;
    localparam int unsigned COEF_W   = 17;
    localparam int unsigned SQ_COEF_W = 34;
    localparam int unsigned LEN2_W   = 34;
    localparam int unsigned PROD_W   = 41;
    localparam int unsigned OFS_W    = 25;
    localparam int unsigned DIST_W   = 43;
    localparam int unsigned MAG_W    = 42;
    localparam int unsigned MAG_HALF = 21;
    localparam int unsigned SQ_W     = 42;
    localparam int unsigned PP_W     = 57;
    localparam int unsigned RL_W     = 80;
    localparam int unsigned D2_W     = 84;
    localparam int unsigned CNT_W    = 2;

    localparam int unsigned IN_DATA_W  = 96;
    localparam int unsigned OUT_DATA_W = 8;

    // straddle count at which a sphere is accepted outright
    localparam logic [CNT_W-1:0] STRADDLE_LIMIT = 2'd3;

    // register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_MATRIX_COL0 = 2'd0;
    localparam logic [1:0] REG_MATRIX_COL1 = 2'd1;
    localparam logic [1:0] REG_MATRIX_COL2 = 2'd2;
    localparam logic [1:0] REG_MATRIX_COL3 = 2'd3;

    localparam logic [COL_W-1:0] MATRIX_COL0_RST = 64'h0000_0000_0000_0100;
    localparam logic [COL_W-1:0] MATRIX_COL1_RST = 64'h0000_0000_0100_0000;
    localparam logic [COL_W-1:0] MATRIX_COL2_RST = 64'h0000_0100_0000_0000;
    localparam logic [COL_W-1:0] MATRIX_COL3_RST = 64'h0100_0000_0000_0000;

    // plane order: left, right, top, bottom, near, far
    localparam logic [1:0] PLANE_ROW [PLANE_COUNT] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic       PLANE_NEG [PLANE_COUNT] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    typedef logic [COL_COUNT-1:0][COL_W-1:0] cols_t;

    typedef struct packed {
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        logic signed [CTR_W-1:0] cz;
        logic [R2_W-1:0]         r2;
    } sphere_t;

    typedef struct packed {
        logic             done;
        logic             vis;
        logic [CNT_W-1:0] cnt;
        logic             degen;
    } status_t;

    typedef struct packed {
        logic degenerate;
        logic visible;
    } result_t;

    localparam status_t STATUS_INIT = '{done: 1'b0, vis: 1'b1, cnt: '0, degen: 1'b0};

    // row 3 plus or minus the selected row of one column
    function automatic logic signed [COEF_W-1:0] plane_coef(
        input logic [COL_W-1:0] col,
        input logic [1:0]       row,
        input logic             neg
    );
        logic [ELEM_W-1:0]        sel;
        logic signed [COEF_W-1:0] base;
        logic signed [COEF_W-1:0] other;
        sel   = col[ELEM_W*row +: ELEM_W];
        base  = $signed({col[COL_W-1], col[COL_W-1 -: ELEM_W]});
        other = $signed({sel[ELEM_W-1], sel});
        return neg ? (base - other) : (base + other);
    endfunction

endpackage

// ===== hdl/frustum_sphere_cull_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_sphere_cull_unit
// Sphere versus view-frustum test against six planes taken from a Q8.8 matrix.
// ----------------------------------------------------------------------------
// Usage:
//  - Spheres arrive on the s_ stream (centre Q16.8, radius Q15.8), one
//    verdict per sphere leaves on the m_ stream (visible, degenerate).
//  - The APB port holds the four matrix columns (64 bits, byte address 8*i).
//    Write them only while no sphere is in flight.
//  - Throughput is one sphere per cycle unless the output buffer is full.
//    m_tvalid follows the input transfer through two input stages, the
//    six-cell chain (each cell a six-stage plane evaluator that hands the
//    sphere to the next cell after its first stage) and the output buffer.
//  - Results leave in input order. A two-entry output buffer sits in front
//    of m_tdata, so inputs keep flowing while one result waits. Once both
//    entries are taken the whole pipeline freezes and s_tready drops;
//    s_tready depends on registered state only.
//  - Reset empties the pipeline and loads the identity matrix.
// ----------------------------------------------------------------------------
module frustum_sphere_cull_unit #(
    parameter int unsigned PLANE_COUNT = fsc_pkg::PLANE_COUNT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fsc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [fsc_pkg::COL_W-1:0]       pwdata,
    output logic [fsc_pkg::COL_W-1:0]       prdata,
    output logic                            pready,
    // sphere input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [23:0] center_x, [47:24] center_y, [71:48] center_z, [94:72] radius, [95] zero
    input  logic [fsc_pkg::IN_DATA_W-1:0]   s_tdata,
    // verdict output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] visible, [1] degenerate, [7:2] zero
    output logic [fsc_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import fsc_pkg::*;

    // ---------------- configuration registers ----------------
    cols_t      cols_reg;
    logic       cfg_write;
    logic [1:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[CFG_ADDR_W-1:3];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg[0] <= MATRIX_COL0_RST;
            cols_reg[1] <= MATRIX_COL1_RST;
            cols_reg[2] <= MATRIX_COL2_RST;
            cols_reg[3] <= MATRIX_COL3_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MATRIX_COL0: cols_reg[0] <= pwdata;
                REG_MATRIX_COL1: cols_reg[1] <= pwdata;
                REG_MATRIX_COL2: cols_reg[2] <= pwdata;
                REG_MATRIX_COL3: cols_reg[3] <= pwdata;
                default:         cols_reg[0] <= cols_reg[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_MATRIX_COL0: prdata = cols_reg[0];
            REG_MATRIX_COL1: prdata = cols_reg[1];
            REG_MATRIX_COL2: prdata = cols_reg[2];
            REG_MATRIX_COL3: prdata = cols_reg[3];
            default:         prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // One enable for every stage: hold everything while the output buffer is full.
    logic queue_full;
    logic advance;
    logic in_xfer;

    assign advance  = ~queue_full;
    assign s_tready = advance;
    assign in_xfer  = s_tvalid & s_tready;

    // ---------------- input stages ----------------
    logic                    in_valid_reg;
    logic signed [CTR_W-1:0] in_cx_reg, in_cy_reg, in_cz_reg;
    logic [RAD_W-1:0]        in_r_reg;
    logic                    pre_valid_reg;
    sphere_t                 pre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pre_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg  <= in_xfer;
            pre_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_cx_reg <= $signed(s_tdata[CTR_W-1:0]);
            in_cy_reg <= $signed(s_tdata[2*CTR_W-1:CTR_W]);
            in_cz_reg <= $signed(s_tdata[3*CTR_W-1:2*CTR_W]);
            in_r_reg  <= s_tdata[3*CTR_W+RAD_W-1:3*CTR_W];
        end
        if (advance)
        begin
            // radius squared once, shared down the chain
            pre_reg.cx <= in_cx_reg;
            pre_reg.cy <= in_cy_reg;
            pre_reg.cz <= in_cz_reg;
            pre_reg.r2 <= R2_W'(in_r_reg) * R2_W'(in_r_reg);
        end
    end

    // ---------------- cell chain ----------------
    // Sphere hops one cell per cycle while the pipeline advances; each cell's
    // registered verdict meets the next cell's test for the same sphere.
    logic    sph_valid [PLANE_COUNT+1];
    sphere_t sph_chain [PLANE_COUNT+1];
    logic    stat_valid [PLANE_COUNT];
    status_t stat_chain [PLANE_COUNT+1];

    assign sph_valid[0]  = pre_valid_reg;
    assign sph_chain[0]  = pre_reg;
    assign stat_chain[0] = STATUS_INIT;

    for (genvar i = 0; i < PLANE_COUNT; i++)
    begin : g_cell
        fsc_cell #(
            .PLANE_IDX (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .advance        (advance),
            .cols           (cols_reg),
            .sph_in_valid   (sph_valid[i]),
            .sph_in         (sph_chain[i]),
            .sph_out_valid  (sph_valid[i+1]),
            .sph_out        (sph_chain[i+1]),
            .stat_in        (stat_chain[i]),
            .stat_out_valid (stat_valid[i]),
            .stat_out       (stat_chain[i+1])
        );
    end

    // ---------------- output ----------------
    status_t final_stat;
    result_t result;
    result_t out_result;
    logic    push;

    assign final_stat        = stat_chain[PLANE_COUNT];
    assign result.visible    = final_stat.vis & ~final_stat.degen;
    assign result.degenerate = final_stat.degen;
    assign push              = advance & stat_valid[PLANE_COUNT-1];

    fsc_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .full      (queue_full),
        .out_valid (m_tvalid),
        .out_data  (out_result),
        .out_ready (m_tready)
    );

    assign m_tdata = {6'b0, out_result.degenerate, out_result.visible};

endmodule

// ===== hdl/fsc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_cell
// One plane of the cull chain: distance and radius terms, exact squared test.
// ----------------------------------------------------------------------------
module fsc_cell #(
    parameter int unsigned PLANE_IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  fsc_pkg::cols_t   cols,
    input  logic             sph_in_valid,
    input  fsc_pkg::sphere_t sph_in,
    output logic             sph_out_valid,
    output fsc_pkg::sphere_t sph_out,
    input  fsc_pkg::status_t stat_in,
    output logic             stat_out_valid,
    output fsc_pkg::status_t stat_out
);
    import fsc_pkg::*;

    localparam logic [1:0] ROW = PLANE_ROW[PLANE_IDX];
    localparam logic       NEG = PLANE_NEG[PLANE_IDX];

    logic signed [COEF_W-1:0]    coef_a, coef_b, coef_c, coef_d;
    logic signed [SQ_COEF_W-1:0] sq_a, sq_b, sq_c;
    logic                        normal_zero;
    logic [LEN2_W-1:0]           len2_reg;

    assign coef_a = plane_coef(cols[0], ROW, NEG);
    assign coef_b = plane_coef(cols[1], ROW, NEG);
    assign coef_c = plane_coef(cols[2], ROW, NEG);
    assign coef_d = plane_coef(cols[3], ROW, NEG);
    assign sq_a   = coef_a * coef_a;
    assign sq_b   = coef_b * coef_b;
    assign sq_c   = coef_c * coef_c;
    assign normal_zero = (coef_a == '0) && (coef_b == '0) && (coef_c == '0);

    // squared normal length, follows the config registers
    always_ff @(posedge clk)
    begin
        len2_reg <= $unsigned(sq_a) + $unsigned(sq_b) + $unsigned(sq_c);
    end

    // stage valids
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg;

    // stage A: products
    sphere_t                  sph_a_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [OFS_W-1:0]  pd_reg;
    logic signed [PROD_W-1:0] px_next, py_next, pz_next;

    assign px_next = coef_a * sph_in.cx;
    assign py_next = coef_b * sph_in.cy;
    assign pz_next = coef_c * sph_in.cz;

    // stage B: distance and radius partial products
    logic signed [DIST_W-1:0] dist_reg, dist_next;
    logic [PP_W-1:0]          pp_lo_reg, pp_hi_reg;

    assign dist_next = px_reg + py_reg + pz_reg + pd_reg;

    // stage C: magnitude, r^2 * L^2
    logic              neg_c_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [RL_W-1:0]   rl_c_reg;
    logic [DIST_W-1:0] abs_dist;

    assign abs_dist = dist_reg[DIST_W-1] ? $unsigned(-dist_reg) : $unsigned(dist_reg);

    // stage D: D^2 partial products
    logic            neg_d_reg;
    logic [RL_W-1:0] rl_d_reg;
    logic [SQ_W-1:0] mh2_reg, mx_reg, ml2_reg;
    logic [MAG_HALF-1:0] mag_hi, mag_lo;

    assign mag_hi = mag_reg[MAG_W-1:MAG_HALF];
    assign mag_lo = mag_reg[MAG_HALF-1:0];

    // stage E: D^2
    logic            neg_e_reg;
    logic [RL_W-1:0] rl_e_reg;
    logic [D2_W-1:0] d2_reg;

    // stage F: decision
    status_t          stat_f_reg, stat_next;
    logic             d_above, d_below;

    assign d_above = d2_reg > D2_W'(rl_e_reg);
    assign d_below = d2_reg < D2_W'(rl_e_reg);

    always_comb
    begin
        stat_next       = stat_in;
        stat_next.degen = stat_in.degen | normal_zero;
        if (!stat_in.done)
        begin
            if (neg_e_reg && d_above)
            begin
                stat_next.vis  = 1'b0;
                stat_next.done = 1'b1;
            end
            else if (d_below)
            begin
                stat_next.cnt = stat_in.cnt + 1'b1;
                if (stat_next.cnt == STRADDLE_LIMIT)
                begin
                    stat_next.done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= sph_in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sph_a_reg <= sph_in;
            px_reg    <= px_next;
            py_reg    <= py_next;
            pz_reg    <= pz_next;
            pd_reg    <= $signed({coef_d, 8'h00});

            dist_reg  <= dist_next;
            pp_lo_reg <= sph_a_reg.r2[R2_HALF-1:0] * len2_reg;
            pp_hi_reg <= sph_a_reg.r2[R2_W-1:R2_HALF] * len2_reg;

            neg_c_reg <= dist_reg[DIST_W-1];
            mag_reg   <= abs_dist[MAG_W-1:0];
            rl_c_reg  <= (RL_W'(pp_hi_reg) << R2_HALF) + RL_W'(pp_lo_reg);

            neg_d_reg <= neg_c_reg;
            rl_d_reg  <= rl_c_reg;
            mh2_reg   <= mag_hi * mag_hi;
            mx_reg    <= mag_hi * mag_lo;
            ml2_reg   <= mag_lo * mag_lo;

            neg_e_reg <= neg_d_reg;
            rl_e_reg  <= rl_d_reg;
            d2_reg    <= (D2_W'(mh2_reg) << (2 * MAG_HALF))
                       + (D2_W'(mx_reg) << (MAG_HALF + 1))
                       + D2_W'(ml2_reg);

            stat_f_reg <= stat_next;
        end
    end

    assign sph_out_valid  = a_valid_reg;
    assign sph_out        = sph_a_reg;
    assign stat_out_valid = f_valid_reg;
    assign stat_out       = stat_f_reg;

endmodule

// ===== hdl/fsc_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_out_queue
// Two-entry output buffer: head register plus skid register.
// ----------------------------------------------------------------------------
module fsc_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fsc_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    output fsc_pkg::result_t out_data,
    input  logic             out_ready
);
    import fsc_pkg::*;

    logic    head_valid_reg, skid_valid_reg;
    result_t head_reg, skid_reg;
    logic    pop;

    assign pop = head_valid_reg & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!head_valid_reg || pop)
        begin
            head_valid_reg <= skid_valid_reg | push;
            skid_valid_reg <= skid_valid_reg & push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!head_valid_reg || pop)
        begin
            head_reg <= skid_valid_reg ? skid_reg : push_data;
            skid_reg <= push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    assign full      = head_valid_reg & skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

endmodule
